### sv/x25519sm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x25519sm_pkg
// Shared types, constants and ladder microcode for the X25519 scalar multiply.
// ----------------------------------------------------------------------------
package x25519sm_pkg;

  localparam int FE_W   = 256;
  localparam int ACC_W  = 262;
  localparam int ADDR_W = 4;

  localparam logic [FE_W-1:0] PRIME =
    256'h7fffffffffffffffffffffffffffffffffffffffffffffffffffffffffffffed;
  localparam logic [ACC_W-1:0] FOUR_PRIME =
    262'h1ffffffffffffffffffffffffffffffffffffffffffffffffffffffffffffffb4;
  localparam logic [FE_W-1:0] A24 = 256'd121665;
  localparam logic [5:0] FOLD_K = 6'd38;

  // field unit operations
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_CAN = 2'd3;

  // field register file slots
  localparam logic [ADDR_W-1:0] R_X2  = 4'd0;
  localparam logic [ADDR_W-1:0] R_Z2  = 4'd1;
  localparam logic [ADDR_W-1:0] R_X3  = 4'd2;
  localparam logic [ADDR_W-1:0] R_Z3  = 4'd3;
  localparam logic [ADDR_W-1:0] R_U   = 4'd4;
  localparam logic [ADDR_W-1:0] R_A   = 4'd5;
  localparam logic [ADDR_W-1:0] R_B   = 4'd6;
  localparam logic [ADDR_W-1:0] R_C   = 4'd7;
  localparam logic [ADDR_W-1:0] R_D   = 4'd8;
  localparam logic [ADDR_W-1:0] R_E   = 4'd9;
  localparam logic [ADDR_W-1:0] R_T   = 4'd10;
  localparam logic [ADDR_W-1:0] R_K   = 4'd11;
  localparam logic [ADDR_W-1:0] R_ONE = 4'd12;

  localparam int REGS = 13;
  localparam logic [4:0] LAD_LAST = 5'd17;

  typedef struct packed {
    logic              start;
    logic [1:0]        op;
  } fau_req_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [ADDR_W-1:0] dst;
    logic [ADDR_W-1:0] s1;
    logic [ADDR_W-1:0] s2;
  } lad_op_t;

  // one ladder step: R0 <- 2*R0, R1 <- R0+R1
  function automatic lad_op_t ladder_op(input logic [4:0] step);
    lad_op_t o;
    case (step)
      5'd0:    o = '{OP_ADD, R_A,  R_X2, R_Z2};
      5'd1:    o = '{OP_SUB, R_B,  R_X2, R_Z2};
      5'd2:    o = '{OP_ADD, R_C,  R_X3, R_Z3};
      5'd3:    o = '{OP_SUB, R_D,  R_X3, R_Z3};
      5'd4:    o = '{OP_MUL, R_D,  R_D,  R_A};
      5'd5:    o = '{OP_MUL, R_C,  R_C,  R_B};
      5'd6:    o = '{OP_MUL, R_A,  R_A,  R_A};
      5'd7:    o = '{OP_MUL, R_B,  R_B,  R_B};
      5'd8:    o = '{OP_MUL, R_X2, R_A,  R_B};
      5'd9:    o = '{OP_SUB, R_E,  R_A,  R_B};
      5'd10:   o = '{OP_MUL, R_T,  R_E,  R_K};
      5'd11:   o = '{OP_ADD, R_T,  R_T,  R_A};
      5'd12:   o = '{OP_MUL, R_Z2, R_E,  R_T};
      5'd13:   o = '{OP_ADD, R_T,  R_D,  R_C};
      5'd14:   o = '{OP_MUL, R_X3, R_T,  R_T};
      5'd15:   o = '{OP_SUB, R_T,  R_D,  R_C};
      5'd16:   o = '{OP_MUL, R_T,  R_T,  R_T};
      5'd17:   o = '{OP_MUL, R_Z3, R_T,  R_U};
      default: o = '{OP_ADD, R_T,  R_T,  R_T};
    endcase
    return o;
  endfunction

endpackage

### sv/x25519sm_fau.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x25519sm_fau
// Iterative GF(2^255-19) unit: add, subtract, 32x32 product-scanning
// multiply with fold by 38, and canonical reduction.
// ----------------------------------------------------------------------------
module x25519sm_fau (
  input  logic                               clk,
  input  logic                               rst_n,
  input  x25519sm_pkg::fau_req_t             req,
  input  logic [x25519sm_pkg::FE_W-1:0]      a,
  input  logic [x25519sm_pkg::FE_W-1:0]      b,
  output logic                               done,
  output logic [x25519sm_pkg::FE_W-1:0]      res
);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_MULP = 3'd1;
  localparam logic [2:0] F_MULA = 3'd2;
  localparam logic [2:0] F_RED  = 3'd3;
  localparam logic [2:0] F_FOLD = 3'd4;
  localparam logic [2:0] F_CAN  = 3'd5;
  localparam logic [2:0] F_DONE = 3'd6;

  logic [2:0]                          st_r;
  logic [x25519sm_pkg::FE_W-1:0]       a_r, b_r;
  logic [511:0]                        t_r;
  logic [69:0]                         col_r;
  logic [63:0]                         pp_r;
  logic [3:0]                          k_r;
  logic [2:0]                          i_r;
  logic [5:0]                          red_c_r;
  logic                                pass_r;
  logic [x25519sm_pkg::ACC_W-1:0]      acc_r;

  logic [3:0]  j_full, k_inc;
  logic [2:0]  i_end, i_next_start;
  logic [69:0] col_sum;
  logic [37:0] red_sum;
  logic [5:0]  hi;

  assign j_full       = k_r - {1'b0, i_r};
  assign k_inc        = k_r + 4'd1;
  assign i_end        = (k_r > 4'd7) ? 3'd7 : k_r[2:0];
  assign i_next_start = (k_inc > 4'd7) ? 3'(k_inc - 4'd7) : 3'd0;
  assign col_sum      = col_r + {6'b0, pp_r};
  assign red_sum      = 38'(red_c_r) + 38'(t_r[{1'b0, i_r, 5'b0} +: 32])
                      + 38'(t_r[{1'b1, i_r, 5'b0} +: 32]) * 38'(x25519sm_pkg::FOLD_K);
  assign hi           = acc_r[x25519sm_pkg::ACC_W-1:x25519sm_pkg::FE_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
    end else begin
      case (st_r)
        F_IDLE: begin
          if (req.start) begin
            a_r <= a;
            b_r <= b;
            case (req.op)
              x25519sm_pkg::OP_ADD: begin
                acc_r <= {6'b0, a} + {6'b0, b};
                st_r  <= F_FOLD;
              end
              x25519sm_pkg::OP_SUB: begin
                acc_r <= {6'b0, a} + x25519sm_pkg::FOUR_PRIME - {6'b0, b};
                st_r  <= F_FOLD;
              end
              x25519sm_pkg::OP_MUL: begin
                k_r   <= 4'd0;
                i_r   <= 3'd0;
                col_r <= '0;
                st_r  <= F_MULP;
              end
              default: begin
                acc_r  <= {6'b0, a};
                pass_r <= 1'b0;
                st_r   <= F_CAN;
              end
            endcase
          end
        end
        F_MULP: begin
          pp_r <= {32'b0, a_r[{i_r, 5'b0} +: 32]} * {32'b0, b_r[{j_full[2:0], 5'b0} +: 32]};
          st_r <= F_MULA;
        end
        F_MULA: begin
          if (i_r == i_end) begin
            col_r <= col_sum >> 32;
            if (k_r == 4'd14) begin
              t_r[448 +: 64] <= col_sum[63:0];
              i_r     <= 3'd0;
              red_c_r <= '0;
              st_r    <= F_RED;
            end else begin
              t_r[{k_r, 5'b0} +: 32] <= col_sum[31:0];
              k_r  <= k_inc;
              i_r  <= i_next_start;
              st_r <= F_MULP;
            end
          end else begin
            col_r <= col_sum;
            i_r   <= i_r + 3'd1;
            st_r  <= F_MULP;
          end
        end
        F_RED: begin
          red_c_r <= red_sum[37:32];
          if (i_r == 3'd7) begin
            acc_r[224 +: 38] <= red_sum;
            st_r <= F_FOLD;
          end else begin
            acc_r[{i_r, 5'b0} +: 32] <= red_sum[31:0];
            i_r <= i_r + 3'd1;
          end
        end
        F_FOLD: begin
          if (hi == 6'd0) begin
            st_r <= F_DONE;
          end else begin
            acc_r <= {6'b0, acc_r[x25519sm_pkg::FE_W-1:0]}
                   + x25519sm_pkg::ACC_W'({6'b0, hi} * 12'(x25519sm_pkg::FOLD_K));
          end
        end
        F_CAN: begin
          if (acc_r[x25519sm_pkg::FE_W-1:0] >= x25519sm_pkg::PRIME) begin
            acc_r <= acc_r - {6'b0, x25519sm_pkg::PRIME};
          end
          pass_r <= 1'b1;
          if (pass_r) begin
            st_r <= F_DONE;
          end
        end
        F_DONE: begin
          st_r <= F_IDLE;
        end
        default: begin
          st_r <= F_IDLE;
        end
      endcase
    end
  end

  assign done = (st_r == F_DONE);
  assign res  = acc_r[x25519sm_pkg::FE_W-1:0];

endmodule

### sv/x25519_scalar_multiply_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x25519_scalar_multiply_top
// X25519 scalar multiplication: Montgomery ladder, inversion and output.
// ----------------------------------------------------------------------------
// Words 0 to 2 are stored as they are transferred. Word 3 starts an exchange
// that holds in_stall high until the results have left: 256 ladder steps of 10
// multiplies and 8 add/subtract operations, then 254 squarings and 253
// multiplies for the inversion, all run one at a time on a single field unit
// whose multiply uses one 32x32 multiplier. The four
// result words then leave in order, one per transfer.
module x25519_scalar_multiply_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_word_index,
  input  logic [63:0] in_scalar_word,
  input  logic [63:0] in_base_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_index,
  output logic [63:0] out_shared_word,
  output logic        out_last_word
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INIT = 3'd1;
  localparam logic [2:0] S_LAD  = 3'd2;
  localparam logic [2:0] S_INV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  localparam logic [1:0] P_RD   = 2'd0;
  localparam logic [1:0] P_GO   = 2'd1;
  localparam logic [1:0] P_WAIT = 2'd2;

  logic [2:0]  state_r;
  logic [1:0]  phase_r;
  logic [2:0]  init_cnt_r;
  logic [7:0]  bit_r;
  logic [4:0]  step_r;
  logic [7:0]  inv_i_r;
  logic        inv_mul_r;
  logic        fin_r;
  logic [1:0]  out_idx_r;
  logic [63:0] scalar_r [4];
  logic [63:0] base_r [4];
  logic [x25519sm_pkg::FE_W-1:0] res_r;
  logic [x25519sm_pkg::FE_W-1:0] rd1_r, rd2_r;
  logic [x25519sm_pkg::FE_W-1:0] regs_m [x25519sm_pkg::REGS];

  logic [255:0] scal, base_u;
  logic         swap, exp_bit, in_xfer, out_xfer;
  x25519sm_pkg::lad_op_t lop, cur;
  x25519sm_pkg::fau_req_t req;
  logic         fau_done;
  logic [x25519sm_pkg::FE_W-1:0] fau_res;
  logic         we;
  logic [x25519sm_pkg::ADDR_W-1:0] wa;
  logic [x25519sm_pkg::FE_W-1:0]   wd;

  function automatic logic [x25519sm_pkg::ADDR_W-1:0] role(
    input logic [x25519sm_pkg::ADDR_W-1:0] r, input logic sw);
    logic [x25519sm_pkg::ADDR_W-1:0] m;
    m = r;
    if (sw) begin
      case (r)
        x25519sm_pkg::R_X2: m = x25519sm_pkg::R_X3;
        x25519sm_pkg::R_X3: m = x25519sm_pkg::R_X2;
        x25519sm_pkg::R_Z2: m = x25519sm_pkg::R_Z3;
        x25519sm_pkg::R_Z3: m = x25519sm_pkg::R_Z2;
        default:            m = r;
      endcase
    end
    return m;
  endfunction

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;
  assign in_stall = (state_r != S_IDLE);

  // clamped scalar and masked base
  always_comb begin
    scal = {scalar_r[3], scalar_r[2], scalar_r[1], scalar_r[0]};
    scal[2:0] = 3'b000;
    scal[255] = 1'b0;
    scal[254] = 1'b1;
    base_u = {base_r[3], base_r[2], base_r[1], base_r[0]};
    base_u[255] = 1'b0;
  end

  assign swap    = scal[bit_r];
  assign exp_bit = (inv_i_r >= 8'd5) || (inv_i_r == 8'd3) || (inv_i_r == 8'd1)
                   || (inv_i_r == 8'd0);
  assign lop     = x25519sm_pkg::ladder_op(step_r);

  always_comb begin
    cur = '{x25519sm_pkg::OP_MUL, x25519sm_pkg::R_T, x25519sm_pkg::R_T, x25519sm_pkg::R_T};
    case (state_r)
      S_LAD: begin
        cur = '{lop.op, role(lop.dst, swap), role(lop.s1, swap), role(lop.s2, swap)};
      end
      S_INV: begin
        if (!inv_mul_r) begin
          cur = '{x25519sm_pkg::OP_MUL, x25519sm_pkg::R_T, x25519sm_pkg::R_T,
                  x25519sm_pkg::R_T};
        end else if (inv_i_r == 8'd254) begin
          cur = '{x25519sm_pkg::OP_MUL, x25519sm_pkg::R_T, x25519sm_pkg::R_ONE,
                  x25519sm_pkg::R_Z2};
        end else begin
          cur = '{x25519sm_pkg::OP_MUL, x25519sm_pkg::R_T, x25519sm_pkg::R_T,
                  x25519sm_pkg::R_Z2};
        end
      end
      S_FIN: begin
        if (!fin_r) begin
          cur = '{x25519sm_pkg::OP_MUL, x25519sm_pkg::R_T, x25519sm_pkg::R_X2,
                  x25519sm_pkg::R_T};
        end else begin
          cur = '{x25519sm_pkg::OP_CAN, x25519sm_pkg::R_T, x25519sm_pkg::R_T,
                  x25519sm_pkg::R_T};
        end
      end
      default: begin
        cur = '{x25519sm_pkg::OP_MUL, x25519sm_pkg::R_T, x25519sm_pkg::R_T,
                x25519sm_pkg::R_T};
      end
    endcase
  end

  assign req.start = (phase_r == P_GO) &&
                     (state_r == S_LAD || state_r == S_INV || state_r == S_FIN);
  assign req.op    = cur.op;

  x25519sm_fau u_fau (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .a     (rd1_r),
    .b     (rd2_r),
    .done  (fau_done),
    .res   (fau_res)
  );

  // register file write port
  always_comb begin
    we = 1'b0;
    wa = cur.dst;
    wd = fau_res;
    if (state_r == S_INIT) begin
      we = 1'b1;
      case (init_cnt_r)
        3'd0: begin wa = x25519sm_pkg::R_X2;  wd = 256'd1;          end
        3'd1: begin wa = x25519sm_pkg::R_Z2;  wd = '0;              end
        3'd2: begin wa = x25519sm_pkg::R_X3;  wd = base_u;          end
        3'd3: begin wa = x25519sm_pkg::R_Z3;  wd = 256'd1;          end
        3'd4: begin wa = x25519sm_pkg::R_U;   wd = base_u;          end
        3'd5: begin wa = x25519sm_pkg::R_K;   wd = x25519sm_pkg::A24; end
        default: begin wa = x25519sm_pkg::R_ONE; wd = 256'd1;       end
      endcase
    end else if (phase_r == P_WAIT && fau_done) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      regs_m[wa] <= wd;
    end
    rd1_r <= regs_m[cur.s1];
    rd2_r <= regs_m[cur.s2];
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      scalar_r[in_word_index] <= in_scalar_word;
      base_r[in_word_index]   <= in_base_word;
    end
    if (state_r == S_FIN && phase_r == P_WAIT && fau_done && fin_r) begin
      res_r <= fau_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      phase_r    <= P_RD;
      init_cnt_r <= '0;
      bit_r      <= '0;
      step_r     <= '0;
      inv_i_r    <= '0;
      inv_mul_r  <= 1'b0;
      fin_r      <= 1'b0;
      out_idx_r  <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_xfer && in_word_index == 2'd3) begin
            state_r    <= S_INIT;
            init_cnt_r <= '0;
          end
        end
        S_INIT: begin
          init_cnt_r <= init_cnt_r + 3'd1;
          if (init_cnt_r == 3'd6) begin
            state_r <= S_LAD;
            phase_r <= P_RD;
            bit_r   <= 8'd255;
            step_r  <= '0;
          end
        end
        S_LAD, S_INV, S_FIN: begin
          case (phase_r)
            P_RD: phase_r <= P_GO;
            P_GO: phase_r <= P_WAIT;
            default: begin
              if (fau_done) begin
                phase_r <= P_RD;
                if (state_r == S_LAD) begin
                  if (step_r == x25519sm_pkg::LAD_LAST) begin
                    step_r <= '0;
                    if (bit_r == 8'd0) begin
                      state_r   <= S_INV;
                      inv_i_r   <= 8'd254;
                      inv_mul_r <= 1'b1;
                    end else begin
                      bit_r <= bit_r - 8'd1;
                    end
                  end else begin
                    step_r <= step_r + 5'd1;
                  end
                end else if (state_r == S_INV) begin
                  if (inv_mul_r) begin
                    if (inv_i_r == 8'd0) begin
                      state_r <= S_FIN;
                      fin_r   <= 1'b0;
                    end else begin
                      inv_i_r   <= inv_i_r - 8'd1;
                      inv_mul_r <= 1'b0;
                    end
                  end else if (exp_bit) begin
                    inv_mul_r <= 1'b1;
                  end else begin
                    inv_i_r <= inv_i_r - 8'd1;
                  end
                end else begin
                  if (!fin_r) begin
                    fin_r <= 1'b1;
                  end else begin
                    state_r   <= S_OUT;
                    out_idx_r <= '0;
                  end
                end
              end
            end
          endcase
        end
        S_OUT: begin
          if (out_xfer) begin
            out_idx_r <= out_idx_r + 2'd1;
            if (out_idx_r == 2'd3) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = (state_r == S_OUT);
  assign out_index       = out_idx_r;
  assign out_shared_word = res_r[{out_idx_r, 6'b0} +: 64];
  assign out_last_word   = (out_idx_r == 2'd3);

`ifndef SYNTHESIS
  a_no_input_while_output: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while results pending");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_word && !out_stall |=> !out_valid && !in_stall)
    else $error("block not idle after last result transfer");

  a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    fau_done |-> (phase_r == P_WAIT))
    else $error("field unit finished outside wait phase");
`endif

endmodule
